// ===== sv/stm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: shared package
// Widths, codes and the stored entry layout used by the channels and the core.
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int IDX_W    = 16;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = VAL_W + 1;
  localparam int REG_W    = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD_A = 2'd1,
    CMD_LOAD_B = 2'd2,
    CMD_START  = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== sv/stm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: command channel
// Valid/ready channel that carries one command word with its entry fields.
// ----------------------------------------------------------------------------
interface stm_in_if;
  logic                               valid;
  logic                               ready;
  stm_pkg::command_e                  command;
  logic [stm_pkg::IDX_W-1:0]          entry_row;
  logic [stm_pkg::IDX_W-1:0]          entry_col;
  logic signed [stm_pkg::VAL_W-1:0]   entry_value;

  modport source (output valid, command, entry_row, entry_col, entry_value, input ready);
  modport sink   (input valid, command, entry_row, entry_col, entry_value, output ready);
endinterface
`default_nettype wire

// ===== sv/stm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: result channel
// Valid/ready channel that carries one result triplet word with status and last.
// ----------------------------------------------------------------------------
interface stm_out_if;
  logic                               valid;
  logic                               ready;
  logic [stm_pkg::IDX_W-1:0]          sum_row;
  logic [stm_pkg::IDX_W-1:0]          sum_col;
  logic signed [stm_pkg::SUM_W-1:0]   sum_value;
  stm_pkg::status_e                   status;
  logic                               last;

  modport source (output valid, sum_row, sum_col, sum_value, status, last, input ready);
  modport sink   (input valid, sum_row, sum_col, sum_value, status, last, output ready);
endinterface
`default_nettype wire

// ===== sv/sparse_triplet_matrix_add_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A mismatch or empty status word is presented in the cycle after its start word
// is accepted; the first merged triplet is read from the list RAMs in the merge
// state and registered once the output register is free. The merge emits one
// triplet per cycle while the output register is free, set by the single read
// port of each list RAM. A word is taken only while the core is idle and the output
// register is free. Reset clears the fill counts, the dimension registers and the
// output register; the list RAMs are not initialized and need no clearing pass.
// ----------------------------------------------------------------------------
// Sparse triplet matrix add core
// Loads two sorted triplet lists into RAMs and merges them into their sum.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  stm_in_if.sink                             in_i,
  stm_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [stm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [stm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import stm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_a_q, count_a_d;
  logic [CNT_W-1:0] count_b_q, count_b_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [REG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  logic                    out_valid_q, out_valid_d;
  logic [IDX_W-1:0]        out_row_q, out_row_d;
  logic [IDX_W-1:0]        out_col_q, out_col_d;
  logic signed [SUM_W-1:0] out_val_q, out_val_d;
  status_e                 out_status_q, out_status_d;
  logic                    out_last_q, out_last_d;

  logic   we_a, we_b;
  entry_t wentry;
  entry_t head_a, head_b;
  logic [ENTRY_W-1:0] rdata_a, rdata_b;

  logic   out_free, accept, cfg_write;
  logic   a_have, b_have, a_first, b_first;
  logic [CNT_W-1:0] i_n, j_n;
  reg_idx_e reg_idx;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_A_ROWS: prdata = PDATA_W'(a_rows_q);
      REG_A_COLS: prdata = PDATA_W'(a_cols_q);
      REG_B_ROWS: prdata = PDATA_W'(b_rows_q);
      REG_B_COLS: prdata = PDATA_W'(b_cols_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= '0;
      a_cols_q <= '0;
      b_rows_q <= '0;
      b_cols_q <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_A_ROWS: a_rows_q <= pwdata[REG_W-1:0];
        REG_A_COLS: a_cols_q <= pwdata[REG_W-1:0];
        REG_B_ROWS: b_rows_q <= pwdata[REG_W-1:0];
        REG_B_COLS: b_cols_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // List RAMs. The read address follows the next merge index so that the
  // registered read data matches the current merge index.
  assign wentry.row = in_i.entry_row;
  assign wentry.col = in_i.entry_col;
  assign wentry.val = in_i.entry_value;

  stm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (count_a_q[ADDR_W-1:0]),
    .wdata_i (wentry),
    .raddr_i (i_d[ADDR_W-1:0]),
    .rdata_o (rdata_a)
  );

  stm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (count_b_q[ADDR_W-1:0]),
    .wdata_i (wentry),
    .raddr_i (j_d[ADDR_W-1:0]),
    .rdata_o (rdata_b)
  );

  assign head_a = entry_t'(rdata_a);
  assign head_b = entry_t'(rdata_b);

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;

  // Merge head selection in row-major order.
  assign a_have  = i_q < count_a_q;
  assign b_have  = j_q < count_b_q;
  assign a_first = a_have && (!b_have || {head_a.row, head_a.col} < {head_b.row, head_b.col});
  assign b_first = b_have && (!a_have || {head_b.row, head_b.col} < {head_a.row, head_a.col});
  assign i_n     = (a_have && !b_first) ? i_q + CNT_W'(1) : i_q;
  assign j_n     = (b_have && !a_first) ? j_q + CNT_W'(1) : j_q;

  always_comb begin
    state_d      = state_q;
    count_a_d    = count_a_q;
    count_b_d    = count_b_q;
    i_d          = i_q;
    j_d          = j_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_val_d    = out_val_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    we_a         = 1'b0;
    we_b         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.command)
            CMD_CLEAR: begin
              count_a_d = '0;
              count_b_d = '0;
            end
            CMD_LOAD_A: begin
              if (count_a_q < CNT_W'(CAPACITY)) begin
                we_a      = 1'b1;
                count_a_d = count_a_q + CNT_W'(1);
              end
            end
            CMD_LOAD_B: begin
              if (count_b_q < CNT_W'(CAPACITY)) begin
                we_b      = 1'b1;
                count_b_d = count_b_q + CNT_W'(1);
              end
            end
            CMD_START: begin
              i_d = '0;
              j_d = '0;
              if (a_rows_q != b_rows_q || a_cols_q != b_cols_q) begin
                out_valid_d  = 1'b1;
                out_row_d    = '0;
                out_col_d    = '0;
                out_val_d    = '0;
                out_status_d = ST_MISMATCH;
                out_last_d   = 1'b1;
              end else if (count_a_q == '0 && count_b_q == '0) begin
                out_valid_d  = 1'b1;
                out_row_d    = '0;
                out_col_d    = '0;
                out_val_d    = '0;
                out_status_d = ST_EMPTY;
                out_last_d   = 1'b1;
              end else begin
                state_d = S_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_VALID;
          if (a_first) begin
            out_row_d = head_a.row;
            out_col_d = head_a.col;
            out_val_d = SUM_W'(head_a.val);
          end else if (b_first) begin
            out_row_d = head_b.row;
            out_col_d = head_b.col;
            out_val_d = SUM_W'(head_b.val);
          end else begin
            // Equal coordinates: both heads are consumed and summed.
            out_row_d = head_a.row;
            out_col_d = head_a.col;
            out_val_d = SUM_W'(head_a.val) + SUM_W'(head_b.val);
          end
          out_last_d = !(i_n < count_a_q || j_n < count_b_q);
          i_d        = i_n;
          j_d        = j_n;
          if (out_last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_a_q    <= '0;
      count_b_q    <= '0;
      i_q          <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_val_q    <= '0;
      out_status_q <= ST_VALID;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_a_q    <= count_a_d;
      count_b_q    <= count_b_d;
      i_q          <= i_d;
      j_q          <= j_d;
      out_valid_q  <= out_valid_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      out_val_q    <= out_val_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sum_row   = out_row_q;
  assign out_o.sum_col   = out_col_q;
  assign out_o.sum_value = out_val_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

endmodule
`default_nettype wire

// ===== sv/stm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: generic RAM
// One write port and one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module stm_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== bench/stm_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: result checker
// Watches the command, result and register ports. It keeps its own copy of
// the two triplet lists and the dimension registers, works out the merged
// sum for every start word, and compares each result word with the oldest
// one still due.
// ----------------------------------------------------------------------------
module stm_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  stm_in_if                            in_mon,
  stm_out_if                           out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [stm_pkg::PADDR_W-1:0]  paddr,
  input  logic [stm_pkg::PDATA_W-1:0]  pwdata,
  output int                           err_count_o,
  output int                           pending_o
);
  import stm_pkg::*;

  localparam int MAX_SUMS = 2 * CAPACITY;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    status_e                 status;
    logic                    last;
  } sum_word_t;

  sum_word_t   sums_due[$];
  entry_t      list_a[CAPACITY];
  entry_t      list_b[CAPACITY];
  int unsigned fill_a;
  int unsigned fill_b;
  logic [REG_W-1:0] dim_reg[4];

  function automatic logic precedes(entry_t x, entry_t y);
    return (x.row < y.row) || (x.row == y.row && x.col < y.col);
  endfunction

  function automatic logic signed [SUM_W-1:0] widen(logic signed [VAL_W-1:0] v);
    return {v[VAL_W-1], v};
  endfunction

  function automatic sum_word_t make_word(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                          logic signed [SUM_W-1:0] value, status_e status);
    sum_word_t w;
    w.row    = row;
    w.col    = col;
    w.value  = value;
    w.status = status;
    w.last   = 1'b0;
    return w;
  endfunction

  // Row-major merge of both lists; equal coordinates collapse into one sum.
  task automatic queue_merged_sum();
    sum_word_t   batch[MAX_SUMS];
    int unsigned ia;
    int unsigned ib;
    int          k;
    ia = 0;
    ib = 0;
    k  = 0;
    while (ia < fill_a && ib < fill_b) begin
      if (precedes(list_a[ia], list_b[ib])) begin
        batch[k] = make_word(list_a[ia].row, list_a[ia].col, widen(list_a[ia].val), ST_VALID);
        ia++;
      end else if (precedes(list_b[ib], list_a[ia])) begin
        batch[k] = make_word(list_b[ib].row, list_b[ib].col, widen(list_b[ib].val), ST_VALID);
        ib++;
      end else begin
        batch[k] = make_word(list_a[ia].row, list_a[ia].col,
                             widen(list_a[ia].val) + widen(list_b[ib].val), ST_VALID);
        ia++;
        ib++;
      end
      k++;
    end
    while (ia < fill_a) begin
      batch[k] = make_word(list_a[ia].row, list_a[ia].col, widen(list_a[ia].val), ST_VALID);
      ia++;
      k++;
    end
    while (ib < fill_b) begin
      batch[k] = make_word(list_b[ib].row, list_b[ib].col, widen(list_b[ib].val), ST_VALID);
      ib++;
      k++;
    end
    batch[k-1].last = 1'b1;
    for (int n = 0; n < k; n++) begin
      sums_due.push_back(batch[n]);
    end
  endtask

  task automatic take_command();
    entry_t    e;
    sum_word_t w;
    e.row = in_mon.entry_row;
    e.col = in_mon.entry_col;
    e.val = in_mon.entry_value;
    case (in_mon.command)
      CMD_CLEAR: begin
        fill_a = 0;
        fill_b = 0;
      end
      CMD_LOAD_A: begin
        if (fill_a < CAPACITY) begin
          list_a[fill_a] = e;
          fill_a++;
        end
      end
      CMD_LOAD_B: begin
        if (fill_b < CAPACITY) begin
          list_b[fill_b] = e;
          fill_b++;
        end
      end
      default: begin
        if (dim_reg[REG_A_ROWS] != dim_reg[REG_B_ROWS] ||
            dim_reg[REG_A_COLS] != dim_reg[REG_B_COLS]) begin
          w = make_word('0, '0, '0, ST_MISMATCH);
          w.last = 1'b1;
          sums_due.push_back(w);
        end else if (fill_a == 0 && fill_b == 0) begin
          w = make_word('0, '0, '0, ST_EMPTY);
          w.last = 1'b1;
          sums_due.push_back(w);
        end else begin
          queue_merged_sum();
        end
      end
    endcase
  endtask

  task automatic check_result();
    sum_word_t w;
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected result word: row %h col %h value %h status %0d last %b",
               $time, out_mon.sum_row, out_mon.sum_col, out_mon.sum_value,
               out_mon.status, out_mon.last);
      err_count_o++;
    end else begin
      w = sums_due.pop_front();
      if (w.row !== out_mon.sum_row || w.col !== out_mon.sum_col ||
          w.value !== out_mon.sum_value || w.status !== out_mon.status ||
          w.last !== out_mon.last) begin
        $display("%0t: result mismatch: expected row %h col %h value %h status %0d last %b",
                 $time, w.row, w.col, w.value, w.status, w.last);
        $display("%0t:                  actual   row %h col %h value %h status %0d last %b",
                 $time, out_mon.sum_row, out_mon.sum_col, out_mon.sum_value,
                 out_mon.status, out_mon.last);
        err_count_o++;
      end
    end
  endtask

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_a = 0;
      fill_b = 0;
      for (int n = 0; n < 4; n++) begin
        dim_reg[n] = '0;
      end
      sums_due.delete();
    end else begin
      // A result can never come from a start taken at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        take_command();
      end
      if (psel && penable && pwrite && pready) begin
        dim_reg[paddr[PADDR_W-1:2]] = pwdata[REG_W-1:0];
      end
    end
    pending_o = sums_due.size();
  end

endmodule

// ===== bench/tb_sparse_triplet_matrix_add_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse triplet matrix add: testbench top
// Drives command words and register writes into the core, stalls the result side
// at random, and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_matrix_add_core;
  import stm_pkg::*;

  localparam int CYCLE_LIMIT    = 2000000;
  localparam int RANDOM_ITEMS   = 320;
  localparam int NUM_PHASES     = 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int MAX_GAP        = 13;

  logic clk_i;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int   err_count;
  int   pending;
  int   items_sent  = 0;
  logic no_idle     = 1'b0;
  logic rx_hold_req = 1'b0;

  entry_t list_a_q[$];
  entry_t list_b_q[$];

  stm_in_if  cmd_bus ();
  stm_out_if sum_bus ();

  sparse_triplet_matrix_add_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_bus),
    .out_o   (sum_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stm_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (cmd_bus),
    .out_mon     (sum_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(VAL_W-1){1'b1}}};
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  // Each word waits a random gap first; with no gap, valid simply stays high.
  task automatic send_word(command_e cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic signed [VAL_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= cmd;
    cmd_bus.entry_row   <= row;
    cmd_bus.entry_col   <= col;
    cmd_bus.entry_value <= value;
    do @(posedge clk_i); while (!cmd_bus.ready);
    items_sent++;
  endtask

  task automatic send_entry(command_e cmd, entry_t e);
    send_word(cmd, e.row, e.col, e.val);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The sender goes quiet until every result is in, then lets the core settle.
  task automatic wait_results_done();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Builds two row-major sorted lists from one walk over coordinates, so that
  // some coordinates land in both lists and their values get added.
  task automatic build_lists(input bit fill_both_full);
    int               n_pool;
    int               share;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    entry_t           e;
    list_a_q.delete();
    list_b_q.delete();
    if (fill_both_full) n_pool = CAPACITY + 4;
    else if ($urandom_range(0, 7) == 0) n_pool = $urandom_range(10, 28);
    else n_pool = $urandom_range(0, 8);
    r = $urandom_range(0, 2) == 0 ? 16'($urandom_range(65500, 65535)) : 16'($urandom);
    c = 16'($urandom);
    for (int k = 0; k < n_pool; k++) begin
      e.row = r;
      e.col = c;
      e.val = rand_value();
      share = fill_both_full ? 2 : $urandom_range(0, 2);
      if (share != 1) list_a_q.push_back(e);
      if (share == 1) list_b_q.push_back(e);
      if (share == 2) begin
        // Now and then the partner cancels, so a zero sum goes out as well.
        if ($urandom_range(0, 3) == 0) e.val = -e.val;
        else e.val = rand_value();
        list_b_q.push_back(e);
      end
      if ($urandom_range(0, 2) == 0 || c > 16'd65035) begin
        if (r > 16'd65532) break;
        r = r + 16'($urandom_range(1, 3));
        c = 16'($urandom_range(0, 50));
      end else begin
        c = c + 16'($urandom_range(1, 500));
      end
    end
  endtask

  task automatic send_lists();
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < list_a_q.size() || ib < list_b_q.size()) begin
      if (ib >= list_b_q.size() || (ia < list_a_q.size() && $urandom_range(0, 1) == 1)) begin
        send_entry(CMD_LOAD_A, list_a_q[ia]);
        ia++;
      end else begin
        send_entry(CMD_LOAD_B, list_b_q[ib]);
        ib++;
      end
    end
  endtask

  // Mostly clear, load two sorted lists, start. Some sequences skip the clear
  // and append to old lists; a few are raw noise.
  task automatic run_sequence(input bit fill_both_full);
    int kind;
    int n;
    kind    = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 4) == 0);
    if (!fill_both_full && kind == 0) begin
      n = $urandom_range(2, 8);
      repeat (n) begin
        send_word(command_e'(2'($urandom_range(0, 3))), 16'($urandom), 16'($urandom),
                  $urandom);
      end
    end else begin
      if (fill_both_full || kind != 1) begin
        send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      end
      build_lists(fill_both_full || $urandom_range(0, 14) == 0);
      send_lists();
      send_word(CMD_START, 16'($urandom), 16'($urandom), $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned      cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int stall;
    sum_bus.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = RX_HOLD_CYCLES;
      end
      if (stall > 0) begin
        sum_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      sum_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!sum_bus.valid);
    end
  end

  initial begin
    entry_t           e;
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] rows_b;
    logic [REG_W-1:0] cols_b;
    int               target;
    logic signed [VAL_W-1:0] v_max;
    logic signed [VAL_W-1:0] v_min;

    v_max = {1'b0, {(VAL_W-1){1'b1}}};
    v_min = {1'b1, {(VAL_W-1){1'b0}}};

    rst_ni              = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.command     = CMD_CLEAR;
    cmd_bus.entry_row   = '0;
    cmd_bus.entry_col   = '0;
    cmd_bus.entry_value = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Dimensions are all zero after reset, so they match: an empty start.
    send_word(CMD_START, '0, '0, '0);

    // Extreme coordinates and values, sums at both ends and a zero sum.
    send_word(CMD_LOAD_A, 16'd0, 16'd0, v_min);
    send_word(CMD_LOAD_A, 16'd0, 16'd5, 32'sd7);
    send_word(CMD_LOAD_A, 16'd1, 16'd0, 32'sd1);
    send_word(CMD_LOAD_A, 16'hFFFF, 16'hFFFF, v_max);
    send_word(CMD_LOAD_B, 16'd0, 16'd0, v_min);
    send_word(CMD_LOAD_B, 16'd0, 16'd5, -32'sd7);
    send_word(CMD_LOAD_B, 16'd2, 16'd3, -32'sd1);
    send_word(CMD_LOAD_B, 16'hFFFF, 16'hFFFF, v_max);
    send_word(CMD_START, '1, '1, '1);

    // Unsorted A and a duplicate coordinate in B.
    send_word(CMD_CLEAR, '0, '0, '0);
    send_word(CMD_LOAD_A, 16'd5, 16'd5, 32'sd1);
    send_word(CMD_LOAD_A, 16'd1, 16'd1, 32'sd2);
    send_word(CMD_LOAD_B, 16'd3, 16'd3, 32'sd3);
    send_word(CMD_LOAD_B, 16'd5, 16'd5, 32'sd4);
    send_word(CMD_LOAD_B, 16'd5, 16'd5, -32'sd4);
    send_word(CMD_START, '0, '0, '0);

    // Only one list holds entries.
    send_word(CMD_CLEAR, '0, '0, '0);
    send_word(CMD_LOAD_B, 16'd7, 16'd9, -32'sd3);
    send_word(CMD_START, '0, '0, '0);
    send_word(CMD_CLEAR, '0, '0, '0);
    send_word(CMD_LOAD_A, 16'd4, 16'd4, 32'sd9);
    send_word(CMD_START, '0, '0, '0);

    // Dimensions differ: a single mismatch word.
    wait_results_done();
    cfg_write(REG_A_ROWS, 16'hFFFF);
    send_word(CMD_START, '0, '0, '0);
    wait_results_done();

    for (int p = 0; p < NUM_PHASES; p++) begin
      rows = 16'($urandom);
      cols = 16'($urandom);
      if (p == 0) begin
        rows = '1;
        cols = '1;
      end
      if (p == NUM_PHASES - 1) begin
        rows = '0;
        cols = '0;
      end
      rows_b = rows;
      cols_b = cols;
      if (p == 2) cols_b = cols ^ (16'd1 << $urandom_range(0, 15));
      if (p == 5) rows_b = rows ^ 16'h8000;
      cfg_write(REG_A_ROWS, rows);
      cfg_write(REG_A_COLS, cols);
      cfg_write(REG_B_ROWS, rows_b);
      cfg_write(REG_B_COLS, cols_b);

      if (p == 3) begin
        // The result side holds off for a long stretch while starts keep
        // coming, so the output register fills and the command side stalls.
        rx_hold_req = 1'b1;
        no_idle     = 1'b1;
        send_word(CMD_CLEAR, '0, '0, '0);
        build_lists(1'b0);
        send_lists();
        e.row = 16'($urandom);
        e.col = 16'($urandom);
        e.val = rand_value();
        send_entry(CMD_LOAD_A, e);
        repeat (8) send_word(CMD_START, 16'($urandom), 16'($urandom), $urandom);
        no_idle = 1'b0;
      end

      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      if (p == 0) run_sequence(1'b1);
      while (items_sent < target) run_sequence(1'b0);
      wait_results_done();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sparse_triplet_matrix_add_core.f =====
sv/stm_pkg.sv
sv/stm_in_if.sv
sv/stm_out_if.sv
sv/stm_ram.sv
sv/sparse_triplet_matrix_add_core.sv
bench/stm_result_checker.sv
bench/tb_sparse_triplet_matrix_add_core.sv
